// ===== rtl/core/lo_pkg.sv =====
// Shared types and constants for the lights-out minimum press solver.
`default_nettype none
package lo_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam logic [5:0] NODE_COUNT_RST = 6'd32;
    localparam logic [5:0] PRESS_SAT = 6'd63;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIV_SCAN,
        ST_SWAP,
        ST_ELIM,
        ST_SUM,
        ST_ENTER,
        ST_RETURN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic init;
        logic edge_en;
        logic wr_a;
        logic wr_b;
    } row_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/lo_item_if.sv =====
// Input request channel carrying an opcode and both ends of an edge.
`default_nettype none
interface lo_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [5:0] first_node;
    logic [5:0] second_node;

    modport source (output valid, output op, output first_node, output second_node,
                    input ready);
    modport sink (input valid, input op, input first_node, input second_node,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lo_result_if.sv =====
// Result output channel carrying the press count and the free-variable flag.
`default_nettype none
interface lo_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] min_presses;
    logic       had_free_variables;

    modport source (output valid, output min_presses, output had_free_variables,
                    input ready);
    modport sink (input valid, input min_presses, input had_free_variables,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lo_cfg_if.sv =====
// Configuration write channel carrying the node count.
`default_nettype none
interface lo_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lo_rows.sv =====
// Row storage of the augmented GF(2) matrix with edge loading and re-initialization.
`default_nettype none
module lo_rows
    import lo_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int RW = MAX_NODES + 1,
    localparam int AW = $clog2(MAX_NODES)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire row_cmd_t      cmd,
    input  wire logic [AW-1:0] edge_a,
    input  wire logic [AW-1:0] edge_b,
    input  wire logic [AW-1:0] addr_a,
    input  wire logic [RW-1:0] data_a,
    input  wire logic [AW-1:0] addr_b,
    input  wire logic [RW-1:0] data_b,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [RW-1:0] rd_row
);

    logic [RW-1:0] rows_reg [MAX_NODES];

    assign rd_row = rows_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                rows_reg[i] <= (RW'(1) << i) | (RW'(1) << MAX_NODES);
            end
        end
        else if (cmd.init)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                rows_reg[i] <= (RW'(1) << i) | (RW'(1) << MAX_NODES);
            end
        end
        else if (cmd.edge_en)
        begin
            rows_reg[edge_a] <= rows_reg[edge_a] | (RW'(1) << edge_b);
            rows_reg[edge_b] <= rows_reg[edge_b] | (RW'(1) << edge_a);
        end
        else
        begin
            if (cmd.wr_a)
            begin
                rows_reg[addr_a] <= data_a;
            end
            if (cmd.wr_b)
            begin
                rows_reg[addr_b] <= data_b;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lo_ctrl.sv =====
// Sequencer for elimination, counting and the pruned free-variable search.
`default_nettype none
module lo_ctrl
    import lo_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int RW = MAX_NODES + 1,
    localparam int AW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    lo_item_if.sink            item,
    lo_result_if.source        result,
    lo_cfg_if.sink             cfg,
    output row_cmd_t           cmd,
    output logic      [AW-1:0] edge_a,
    output logic      [AW-1:0] edge_b,
    output logic      [AW-1:0] addr_a,
    output logic      [RW-1:0] data_a,
    output logic      [AW-1:0] addr_b,
    output logic      [RW-1:0] data_b,
    output logic      [AW-1:0] rd_addr,
    input  wire logic [RW-1:0] rd_row
);

    state_t state_reg, state_next;
    logic [5:0] node_count_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] num_reg, num_next;
    logic [CW:0] best_reg, best_next;
    logic [AW-1:0] pk_reg, pk_next;
    logic [RW-1:0] piv_reg, piv_next;
    logic [MAX_NODES-1:0] fc_reg, fc_next;
    logic missing_reg, missing_next;
    logic [CW-1:0] partial_reg [MAX_NODES];
    logic part_wr;
    logic [AW-1:0] part_addr;
    logic out_valid_reg, out_valid_next;
    logic [5:0] press_reg, press_next;
    logic free_reg, free_next;

    logic [CW-1:0] n_eff;
    logic [RW-1:0] n_mask, span, free_mask;
    logic [CW-1:0] col_last, x_dec;
    logic [AW-1:0] col_a, idx_a, x_a, xm_a;
    logic edge_ok, v_bit, out_free;
    logic [CW:0] sat_in;

    assign cfg.ready = 1'b1;
    assign item.ready = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.min_presses = press_reg;
    assign result.had_free_variables = free_reg;

    always_comb
    begin
        if (node_count_reg == 6'd0)
        begin
            n_eff = CW'(1);
        end
        else if ({1'b0, node_count_reg} > 7'(MAX_NODES))
        begin
            n_eff = CW'(MAX_NODES);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign col_a = col_reg[AW-1:0];
    assign idx_a = idx_reg[AW-1:0];
    assign x_a = x_reg[AW-1:0];
    assign x_dec = x_reg - CW'(1);
    assign xm_a = x_dec[AW-1:0];
    assign col_last = n_reg - CW'(1);
    assign n_mask = (RW'(1) << n_reg) - RW'(1);
    assign span = (n_mask & ~((RW'(1) << col_reg) - RW'(1))) | (RW'(1) << MAX_NODES);
    assign free_mask = n_mask & ~((RW'(1) << x_reg) - RW'(1));
    assign v_bit = rd_row[RW-1] ^ (^(rd_row[MAX_NODES-1:0] & free_mask[MAX_NODES-1:0]
                                     & fc_reg));
    assign out_free = !out_valid_reg || result.ready;
    assign sat_in = missing_reg ? best_reg : {1'b0, num_reg};

    assign edge_ok = (item.first_node != 6'd0) && (item.second_node != 6'd0)
                     && ({1'b0, item.first_node} <= 7'(MAX_NODES))
                     && ({1'b0, item.second_node} <= 7'(MAX_NODES));
    assign edge_a = AW'(item.first_node - 6'd1);
    assign edge_b = AW'(item.second_node - 6'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            out_valid_reg <= 1'b0;
            missing_reg <= 1'b0;
            fc_reg <= '0;
            best_reg <= '1;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            missing_reg <= missing_next;
            fc_reg <= fc_next;
            best_reg <= best_next;
            if (cfg.valid)
            begin
                node_count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        col_reg <= col_next;
        idx_reg <= idx_next;
        x_reg <= x_next;
        num_reg <= num_next;
        pk_reg <= pk_next;
        piv_reg <= piv_next;
        press_reg <= press_next;
        free_reg <= free_next;
        if (part_wr)
        begin
            partial_reg[part_addr] <= num_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        col_next = col_reg;
        idx_next = idx_reg;
        x_next = x_reg;
        num_next = num_reg;
        best_next = best_reg;
        pk_next = pk_reg;
        piv_next = piv_reg;
        fc_next = fc_reg;
        missing_next = missing_reg;
        out_valid_next = out_valid_reg && !result.ready;
        press_next = press_reg;
        free_next = free_reg;
        part_wr = 1'b0;
        part_addr = xm_a;
        cmd = '0;
        addr_a = idx_a;
        data_a = rd_row;
        addr_b = col_a;
        data_b = piv_reg;
        rd_addr = idx_a;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.op == OP_EDGE)
                    begin
                        cmd.edge_en = edge_ok;
                    end
                    else
                    begin
                        n_next = n_eff;
                        col_next = '0;
                        idx_next = '0;
                        missing_next = 1'b0;
                        state_next = ST_PIV_SCAN;
                    end
                end
            end
            ST_PIV_SCAN:
            begin
                if (rd_row[col_a])
                begin
                    piv_next = rd_row;
                    pk_next = idx_a;
                    state_next = ST_SWAP;
                end
                else if (idx_reg == col_last)
                begin
                    missing_next = 1'b1;
                    if (col_reg == col_last)
                    begin
                        fc_next = '0;
                        best_next = '1;
                        x_next = n_reg;
                        num_next = '0;
                        state_next = ST_ENTER;
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                        idx_next = col_reg + CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SWAP:
            begin
                rd_addr = col_a;
                cmd.wr_a = 1'b1;
                addr_a = pk_reg;
                cmd.wr_b = 1'b1;
                idx_next = '0;
                state_next = ST_ELIM;
            end
            ST_ELIM:
            begin
                if ((idx_reg != col_reg) && rd_row[col_a])
                begin
                    cmd.wr_a = 1'b1;
                    data_a = rd_row ^ (piv_reg & span);
                end
                if (idx_reg == col_last)
                begin
                    if (col_reg == col_last)
                    begin
                        if (missing_reg)
                        begin
                            fc_next = '0;
                            best_next = '1;
                            x_next = n_reg;
                            num_next = '0;
                            state_next = ST_ENTER;
                        end
                        else
                        begin
                            idx_next = '0;
                            num_next = '0;
                            state_next = ST_SUM;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                        idx_next = col_reg + CW'(1);
                        state_next = ST_PIV_SCAN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SUM:
            begin
                num_next = num_reg + CW'(rd_row[RW-1]);
                if (idx_reg == col_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_ENTER:
            begin
                rd_addr = xm_a;
                if ({1'b0, num_reg} >= best_reg)
                begin
                    state_next = ST_RETURN;
                end
                else if (x_reg == '0)
                begin
                    best_next = {1'b0, num_reg};
                    state_next = ST_RETURN;
                end
                else
                begin
                    part_wr = 1'b1;
                    x_next = x_dec;
                    if (rd_row[xm_a])
                    begin
                        num_next = num_reg + CW'(v_bit);
                    end
                end
            end
            ST_RETURN:
            begin
                rd_addr = x_a;
                if (x_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!rd_row[x_a] && !fc_reg[x_a])
                begin
                    fc_next[x_a] = 1'b1;
                    num_next = partial_reg[x_a] + CW'(1);
                    state_next = ST_ENTER;
                end
                else
                begin
                    fc_next[x_a] = 1'b0;
                    x_next = x_reg + CW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    press_next = (sat_in > (CW + 1)'(PRESS_SAT)) ? PRESS_SAT : 6'(sat_in);
                    free_next = missing_reg;
                    cmd.init = 1'b1;
                    missing_next = 1'b0;
                    fc_next = '0;
                    best_next = '1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/lights_out_gf2_min_solver.sv =====
// Top level of the lights-out minimum press solver over GF(2).
// An edge request with both ends in range marks them as neighbors. A solve request runs
// Gauss-Jordan elimination one matrix row per cycle: for each column a pivot scan of one
// to n rows and, when a pivot is found, a swap and a clearing pass over all n rows,
// followed by counting over the n rows or, if a pivot was missing, by a depth-first search
// over the free variables that enters each node of the search tree in ST_ENTER and comes
// back into it in ST_RETURN. The request channel is not ready from the start of a solve
// until its result is handed to the output register.
`default_nettype none
module lights_out_gf2_min_solver
    import lo_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lo_item_if.sink     item,
    lo_result_if.source result,
    lo_cfg_if.sink      cfg
);

    localparam int RW = MAX_NODES + 1;
    localparam int AW = $clog2(MAX_NODES);

    row_cmd_t cmd;
    logic [AW-1:0] edge_a, edge_b, addr_a, addr_b, rd_addr;
    logic [RW-1:0] data_a, data_b, rd_row;

    lo_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .cfg     (cfg),
        .cmd     (cmd),
        .edge_a  (edge_a),
        .edge_b  (edge_b),
        .addr_a  (addr_a),
        .data_a  (data_a),
        .addr_b  (addr_b),
        .data_b  (data_b),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    lo_rows #(.MAX_NODES(MAX_NODES)) u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .edge_a  (edge_a),
        .edge_b  (edge_b),
        .addr_a  (addr_a),
        .data_a  (data_a),
        .addr_b  (addr_b),
        .data_b  (data_b),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

endmodule
`default_nettype wire

// ===== dv/lights_out_gf2_min_solver_tb.sv =====
// Self-checking testbench for the lights-out minimum press solver.
`timescale 1ns / 100ps
module lights_out_gf2_min_solver_tb;
    import lo_pkg::*;

    localparam int NODES = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 2 * NODES * NODES + 200;

    typedef struct {
        logic       op;
        logic [5:0] a;
        logic [5:0] b;
        bit         typed;
        logic [5:0] presses;
        logic       free;
    } stim_row_t;

    typedef struct {
        logic [5:0] presses;
        logic       free;
    } press_result_t;

    logic clk;
    logic rst_n;

    lo_item_if   item_ch ();
    lo_result_if res_ch ();
    lo_cfg_if    cfg_ch ();

    lights_out_gf2_min_solver uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic [NODES-1:0] gf_rows [NODES];
    logic             gf_rhs [NODES];
    logic [NODES-1:0] gf_choice;
    int               gf_best;
    logic             gf_missing;
    logic [5:0]       gf_node_count;

    press_result_t pending_presses [$];
    int  mismatch_count;
    int  cycle_count;
    int  send_gap_pct;
    int  recv_stall_pct;

    stim_row_t directed_rows [15] = '{
        '{OP_SOLVE, 6'd0,  6'd0,  1'b1, 6'd32, 1'b0},
        '{OP_EDGE,  6'd0,  6'd5,  1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd33, 6'd1,  1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd63, 6'd63, 1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd5,  6'd5,  1'b0, 6'd0,  1'b0},
        '{OP_SOLVE, 6'd63, 6'd63, 1'b1, 6'd32, 1'b0},
        '{OP_EDGE,  6'd1,  6'd2,  1'b0, 6'd0,  1'b0},
        '{OP_SOLVE, 6'd0,  6'd0,  1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd1,  6'd32, 1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd32, 6'd31, 1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd16, 6'd17, 1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd2,  6'd3,  1'b0, 6'd0,  1'b0},
        '{OP_SOLVE, 6'd21, 6'd42, 1'b0, 6'd0,  1'b0},
        '{OP_EDGE,  6'd32, 6'd32, 1'b0, 6'd0,  1'b0},
        '{OP_SOLVE, 6'd0,  6'd0,  1'b1, 6'd32, 1'b0}
    };

    logic [5:0] phase_counts [12] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd5, 6'd33,
                                      6'd12, 6'd2, 6'd32, 6'd20, 6'd7, 6'd32};

    function automatic logic [NODES-1:0] column_span(int lo, int hi);
        logic [NODES-1:0] m;
        m = '0;
        for (int c = lo; c <= hi; c++) m[c-1] = 1'b1;
        return m;
    endfunction

    function automatic void clear_matrix();
        for (int r = 0; r < NODES; r++)
        begin
            gf_rows[r] = '0;
            gf_rows[r][r] = 1'b1;
            gf_rhs[r] = 1'b1;
        end
        gf_choice = '0;
        gf_best = 32'h7fffffff;
        gf_missing = 1'b0;
    endfunction

    function automatic void pivot_column(int x, int n);
        logic [NODES-1:0] span;
        logic [NODES-1:0] tmp_row;
        logic tmp_rhs;
        int piv;
        span = column_span(x, n);
        piv = 0;
        for (int r = x; r <= n; r++)
        begin
            if (piv == 0 && gf_rows[r-1][x-1]) piv = r;
        end
        if (piv == 0)
        begin
            gf_missing = 1'b1;
            return;
        end
        if (piv != x)
        begin
            tmp_row = gf_rows[x-1];
            tmp_rhs = gf_rhs[x-1];
            gf_rows[x-1] = gf_rows[piv-1];
            gf_rhs[x-1] = gf_rhs[piv-1];
            gf_rows[piv-1] = tmp_row;
            gf_rhs[piv-1] = tmp_rhs;
        end
        for (int r = 1; r <= n; r++)
        begin
            if (r != x && gf_rows[r-1][x-1])
            begin
                gf_rows[r-1] ^= gf_rows[x-1] & span;
                gf_rhs[r-1] ^= gf_rhs[x-1];
            end
        end
    endfunction

    function automatic void search_presses(int x, int num, int n);
        logic [NODES-1:0] row;
        int v;
        if (num >= gf_best) return;
        if (x == 0)
        begin
            gf_best = num;
            return;
        end
        row = gf_rows[x-1];
        if (row[x-1])
        begin
            v = int'(gf_rhs[x-1] ^ (^(row & column_span(x + 1, n) & gf_choice)));
            search_presses(x - 1, num + v, n);
        end
        else
        begin
            search_presses(x - 1, num, n);
            gf_choice[x-1] = 1'b1;
            search_presses(x - 1, num + 1, n);
            gf_choice[x-1] = 1'b0;
        end
    endfunction

    function automatic bit predict_presses(logic op, logic [5:0] a, logic [5:0] b,
                                           output press_result_t res);
        int n;
        int total;
        if (op == OP_EDGE)
        begin
            if (a != 0 && b != 0 && a <= NODES && b <= NODES)
            begin
                gf_rows[a-1][b-1] = 1'b1;
                gf_rows[b-1][a-1] = 1'b1;
            end
            return 1'b0;
        end
        n = gf_node_count;
        if (n == 0) n = 1;
        if (n > NODES) n = NODES;
        for (int c = 1; c <= n; c++) pivot_column(c, n);
        if (gf_missing)
        begin
            gf_choice = '0;
            gf_best = 32'h7fffffff;
            search_presses(n, 0, n);
            total = gf_best;
        end
        else
        begin
            total = 0;
            for (int r = 0; r < n; r++) total += int'(gf_rhs[r]);
        end
        if (total > 63) total = 63;
        res.presses = 6'(total);
        res.free = gf_missing;
        clear_matrix();
        return 1'b1;
    endfunction

    task automatic send_request(logic op, logic [5:0] a, logic [5:0] b, bit typed,
                                logic [5:0] t_presses, logic t_free);
        press_result_t res;
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.first_node <= a;
        item_ch.second_node <= b;
        do @(posedge clk); while (!item_ch.ready);
        if (predict_presses(op, a, b, res))
        begin
            if (typed)
            begin
                res.presses = t_presses;
                res.free = t_free;
            end
            pending_presses.push_back(res);
        end
        @(negedge clk);
    endtask

    task automatic drain_and_configure(logic [5:0] count);
        item_ch.valid <= 1'b0;
        while (pending_presses.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= count;
        do @(posedge clk); while (!cfg_ch.ready);
        gf_node_count = count;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_presses.size() == 0)
            begin
                $error("unexpected result: min_presses %0d had_free_variables %0d",
                       res_ch.min_presses, res_ch.had_free_variables);
                mismatch_count++;
            end
            else
            begin
                if (res_ch.min_presses !== pending_presses[0].presses)
                begin
                    $error("min_presses expected %0d actual %0d",
                           pending_presses[0].presses, res_ch.min_presses);
                    mismatch_count++;
                end
                if (res_ch.had_free_variables !== pending_presses[0].free)
                begin
                    $error("had_free_variables expected %0d actual %0d",
                           pending_presses[0].free, res_ch.had_free_variables);
                    mismatch_count++;
                end
                void'(pending_presses.pop_front());
            end
        end
    end

    initial
    begin
        int n_eff;
        int sent;
        int k;
        int hi;
        logic [5:0] a;
        logic [5:0] b;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_EDGE;
        item_ch.first_node = '0;
        item_ch.second_node = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        gf_node_count = NODE_COUNT_RST;
        clear_matrix();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 15; i++)
            send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed, directed_rows[i].presses,
                         directed_rows[i].free);

        for (int p = 0; p < 12; p++)
        begin
            drain_and_configure(phase_counts[p]);
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 83; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 83; end
                default: begin send_gap_pct = 15; recv_stall_pct = 15; end
            endcase
            n_eff = (phase_counts[p] == 0) ? 1 : (phase_counts[p] > NODES ? NODES
                                                  : int'(phase_counts[p]));
            sent = 0;
            while (sent < 62)
            begin
                if ($urandom_range(99) < 15)
                begin
                    a = 6'($urandom_range(63));
                    b = 6'($urandom_range(63));
                    send_request(1'($urandom_range(1)), a, b, 1'b0, '0, 1'b0);
                    sent++;
                end
                else
                begin
                    k = $urandom_range(n_eff < 8 ? n_eff + 1 : 8);
                    hi = ($urandom_range(9) == 0) ? NODES : n_eff;
                    for (int e = 0; e < k; e++)
                    begin
                        a = 6'($urandom_range(hi, 1));
                        b = 6'($urandom_range(hi, 1));
                        send_request(OP_EDGE, a, b, 1'b0, '0, 1'b0);
                        sent++;
                    end
                    send_request(OP_SOLVE, 6'($urandom_range(63)), 6'($urandom_range(63)),
                                 1'b0, '0, 1'b0);
                    sent++;
                end
            end
        end

        item_ch.valid <= 1'b0;
        while (pending_presses.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== lights_out_gf2_min_solver.f =====
rtl/core/lo_pkg.sv
rtl/core/lo_item_if.sv
rtl/core/lo_result_if.sv
rtl/core/lo_cfg_if.sv
rtl/core/lo_rows.sv
rtl/core/lo_ctrl.sv
rtl/core/lights_out_gf2_min_solver.sv
dv/lights_out_gf2_min_solver_tb.sv
